// File: hw/rtl/kdr_pkg.sv
package kdr_pkg;

    localparam int ADDR_W = 64;
    localparam int WORD_W = 32;
    localparam int CFG_W  = 7;

    localparam logic [CFG_W-1:0]  RING_SLOTS_RESET = 7'd64;
    localparam int                MIN_SLOTS        = 2;
    localparam logic [WORD_W-1:0] KEYFRAME_FLAGS   = 32'd1;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    typedef enum logic {
        ST_OK    = 1'b0,
        ST_EMPTY = 1'b1
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] size;
        logic [WORD_W-1:0] flags;
        logic [WORD_W-1:0] kind;
    } desc_t;

    typedef struct packed {
        status_t status;
        desc_t   desc;
    } result_t;

endpackage

// File: hw/rtl/kdr_req_if.sv
interface kdr_req_if import kdr_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] in_addr;
    logic [WORD_W-1:0] in_size;
    logic [WORD_W-1:0] in_flags;
    logic [WORD_W-1:0] in_kind;

    modport source (
        output valid, opcode, in_addr, in_size, in_flags, in_kind,
        input  ready
    );

    modport sink (
        input  valid, opcode, in_addr, in_size, in_flags, in_kind,
        output ready
    );

endinterface

// File: hw/rtl/kdr_rsp_if.sv
interface kdr_rsp_if import kdr_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              status;
    logic [ADDR_W-1:0] out_addr;
    logic [WORD_W-1:0] out_size;
    logic [WORD_W-1:0] out_flags;
    logic [WORD_W-1:0] out_kind;

    modport source (
        output valid, status, out_addr, out_size, out_flags, out_kind,
        input  ready
    );

    modport sink (
        input  valid, status, out_addr, out_size, out_flags, out_kind,
        output ready
    );

endinterface

// File: hw/rtl/kdr_ram.sv
module kdr_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/kdr_ctrl.sv
module kdr_ctrl import kdr_pkg::*; #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(MAX_SLOTS+1)-1:0] len,
    input  logic                           clear,
    kdr_req_if.sink                        req,
    kdr_rsp_if.source                      rsp,
    output logic                           ram_we,
    output logic [$clog2(MAX_SLOTS)-1:0]   ram_waddr,
    output desc_t                          ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(MAX_SLOTS)-1:0]   ram_raddr,
    input  desc_t                          ram_rdata
);

    localparam int PW = $clog2(MAX_SLOTS);
    localparam int LW = $clog2(MAX_SLOTS + 1);
    localparam int NW = (PW + 1 > LW) ? PW + 1 : LW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WALK,
        S_CHECK,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [PW-1:0]   rp_reg, rp_next;
    logic [PW-1:0]   wp_reg, wp_next;
    logic            get_reg, get_next;
    result_t         res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    result_t         out_res_reg, out_res_next;

    logic            empty;
    logic            full;
    logic [PW-1:0]   rp_inc;
    logic [PW-1:0]   wp_inc;

    function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p,
                                                input logic [LW-1:0] n);
        logic [NW-1:0] q;
        q = NW'(p) + NW'(1);
        if (q >= NW'(n))
        begin
            return '0;
        end
        return q[PW-1:0];
    endfunction

    assign rp_inc = step_ptr(rp_reg, len);
    assign wp_inc = step_ptr(wp_reg, len);
    assign empty  = (rp_reg == wp_reg);
    assign full   = (wp_inc == rp_reg);

    assign req.ready = (state_reg == S_IDLE);

    assign ram_waddr       = wp_reg;
    assign ram_wdata.addr  = req.in_addr;
    assign ram_wdata.size  = req.in_size;
    assign ram_wdata.flags = req.in_flags;
    assign ram_wdata.kind  = req.in_kind;
    assign ram_raddr       = rp_reg;

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        get_next       = get_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_next = '0;
                    case (op_t'(req.opcode))
                        OP_PUT:
                        begin
                            // slots being walked never include the tail slot
                            ram_we = 1'b1;
                            if (full)
                            begin
                                rp_next    = rp_inc;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                wp_next    = wp_inc;
                                state_next = S_DONE;
                            end
                        end
                        OP_GET, OP_PEEK:
                        begin
                            get_next = (op_t'(req.opcode) == OP_GET);
                            if (empty)
                            begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        OP_FLUSH:
                        begin
                            rp_next    = '0;
                            wp_next    = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_next.status = ST_OK;
                res_next.desc   = ram_rdata;
                if (get_reg)
                begin
                    rp_next = rp_inc;
                end
                state_next = S_DONE;
            end
            S_WALK:
            begin
                // stop at an empty ring, else fetch the head flags
                if (empty)
                begin
                    wp_next    = wp_inc;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (ram_rdata.flags == KEYFRAME_FLAGS)
                begin
                    wp_next    = wp_inc;
                    state_next = S_DONE;
                end
                else
                begin
                    rp_next    = rp_inc;
                    state_next = S_WALK;
                end
            end
            S_DONE:
            begin
                // hand the word to the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear)
        begin
            rp_next = '0;
            wp_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            get_reg       <= 1'b0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            get_reg       <= get_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_res_reg.status;
    assign rsp.out_addr  = out_res_reg.desc.addr;
    assign rsp.out_size  = out_res_reg.desc.size;
    assign rsp.out_flags = out_res_reg.desc.flags;
    assign rsp.out_kind  = out_res_reg.desc.kind;

endmodule

// File: hw/rtl/keyframe_drop_descriptor_ring_unit.sv
// Channel    Role      Payload
// req        sink      opcode, in_addr, in_size, in_flags, in_kind
// rsp        source    status, out_addr, out_size, out_flags, out_kind
// cfg        write     cfg_we, cfg_data (ring_slots, 7 bits)
//
// Put on a ring with room, flush and empty get/peek go from accept to S_DONE, and
// S_DONE hands the word to the output register once it is free. A get/peek that
// hits passes through S_READ for its RAM read first. A put on a full ring walks
// S_WALK and S_CHECK for each slot the drop walk reads, plus S_WALK if it ends empty.
// Reset clears the pointers, not the RAM; the RAM keeps no valid bits or clear pass.
// A stalled output register holds its word; one more item can finish behind it.
module keyframe_drop_descriptor_ring_unit import kdr_pkg::*; #(
    parameter int MAX_SLOTS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    kdr_req_if.sink          req,
    kdr_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int PW = $clog2(MAX_SLOTS);
    localparam int LW = $clog2(MAX_SLOTS + 1);
    localparam int CW = (LW > CFG_W) ? LW : CFG_W;

    logic [CFG_W-1:0] ring_slots_reg;
    logic [CW-1:0]    slots_ext;
    logic [LW-1:0]    len;

    logic             ram_we;
    logic [PW-1:0]    ram_waddr;
    desc_t            ram_wdata;
    logic             ram_re;
    logic [PW-1:0]    ram_raddr;
    desc_t            ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_slots_reg <= RING_SLOTS_RESET;
        end
        else if (cfg_we)
        begin
            ring_slots_reg <= cfg_data;
        end
    end

    // clamp the ring size into the supported range
    assign slots_ext = CW'(ring_slots_reg);
    assign len = (slots_ext < CW'(MIN_SLOTS)) ? LW'(MIN_SLOTS) :
                 (slots_ext > CW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) :
                 LW'(slots_ext);

    kdr_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .len       (len),
        .clear     (cfg_we),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    kdr_ram #(
        .WIDTH ($bits(desc_t)),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// File: hw/rtl/kdr_checker.sv
module kdr_checker import kdr_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_status,
    input logic [ADDR_W-1:0] rsp_addr,
    input logic [WORD_W-1:0] rsp_size,
    input logic [WORD_W-1:0] rsp_flags,
    input logic [WORD_W-1:0] rsp_kind
);

    // a stalled result word holds its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
            $stable(rsp_addr) && $stable(rsp_size) && $stable(rsp_flags) &&
            $stable(rsp_kind))
    else $error("result word changed while stalled");

    // an empty status carries no descriptor
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status |-> rsp_addr == '0 && rsp_size == '0 &&
            rsp_flags == '0 && rsp_kind == '0)
    else $error("empty status with nonzero descriptor");

    // one word at a time: ready drops right after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("second word accepted back to back");

    // a new result only appears while the request side is busy finishing it
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared without a finished item");

endmodule

bind keyframe_drop_descriptor_ring_unit kdr_checker u_kdr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_addr   (rsp.out_addr),
    .rsp_size   (rsp.out_size),
    .rsp_flags  (rsp.out_flags),
    .rsp_kind   (rsp.out_kind)
);

// File: tb/tb_keyframe_drop_descriptor_ring_unit.sv
`timescale 1ns / 100ps

module tb_keyframe_drop_descriptor_ring_unit;
    import kdr_pkg::*;

    localparam int RING_DEPTH = 64;
    localparam int RAND_WORDS = 1900;

    typedef struct {
        op_t   op;
        desc_t desc;
    } ring_req_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    kdr_req_if req_if ();
    kdr_rsp_if rsp_if ();

    keyframe_drop_descriptor_ring_unit #(
        .MAX_SLOTS(RING_DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if.sink),
        .rsp     (rsp_if.source),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data)
    );

    // ring shadow
    desc_t      ring_mem [RING_DEPTH];
    logic [5:0] head_ptr  = '0;
    logic [5:0] tail_ptr  = '0;
    logic [6:0] ring_len  = RING_SLOTS_RESET;

    ring_req_t  req_pending [$];
    result_t    due_results [$];

    int  idle_pct     = 33;
    int  words_in     = 0;
    int  fails        = 0;
    bit  req_taken    = 1'b0;
    int  rx_hold      = 0;
    bit  rx_hold_done = 1'b0;

    int  n_put = 0, n_full_put = 0, n_get = 0, n_peek = 0, n_flush = 0, n_empty = 0;
    int  n_key_stop = 0, n_resize = 0;

    always #5 clk = ~clk;

    function automatic logic [5:0] ring_next(logic [5:0] p);
        logic [6:0] q;
        q = {1'b0, p} + 7'd1;
        return (q >= ring_len) ? 6'd0 : q[5:0];
    endfunction

    function automatic void ring_resize_shadow(logic [CFG_W-1:0] v);
        if (v < MIN_SLOTS)
            ring_len = 7'(MIN_SLOTS);
        else if (v > RING_DEPTH)
            ring_len = 7'(RING_DEPTH);
        else
            ring_len = v;
        head_ptr = '0;
        tail_ptr = '0;
    endfunction

    // Compute the word the block owes for one request and advance the shadow ring.
    function automatic result_t ring_apply(op_t op, desc_t d);
        result_t r;
        int      n;
        r        = '0;
        r.status = ST_OK;
        case (op)
            OP_PUT:
            begin
                n_put++;
                if (ring_next(tail_ptr) == head_ptr)
                begin
                    n_full_put++;
                    head_ptr = ring_next(head_ptr);
                    n        = 0;
                    // drop stale entries up to the next keyframe
                    while (n < RING_DEPTH && head_ptr != tail_ptr &&
                           ring_mem[head_ptr].flags != KEYFRAME_FLAGS)
                    begin
                        head_ptr = ring_next(head_ptr);
                        n++;
                    end
                    if (head_ptr != tail_ptr)
                        n_key_stop++;
                end
                ring_mem[tail_ptr] = d;
                tail_ptr           = ring_next(tail_ptr);
            end
            OP_GET, OP_PEEK:
            begin
                if (op == OP_GET)
                    n_get++;
                else
                    n_peek++;
                if (head_ptr == tail_ptr)
                begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    r.desc = ring_mem[head_ptr];
                    if (op == OP_GET)
                        head_ptr = ring_next(head_ptr);
                end
            end
            default:
            begin
                n_flush++;
                head_ptr = '0;
                tail_ptr = '0;
            end
        endcase
        return r;
    endfunction

    function automatic desc_t rand_desc(int key_pct);
        desc_t d;
        d.addr = {$urandom, $urandom};
        d.size = $urandom;
        d.kind = $urandom;
        if ($urandom_range(0, 99) < key_pct)
            d.flags = KEYFRAME_FLAGS;
        else
        begin
            d.flags = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
            if (d.flags == KEYFRAME_FLAGS)
                d.flags = '0;
        end
        return d;
    endfunction

    function automatic void offer(op_t op, desc_t d);
        ring_req_t it;
        it.op   = op;
        it.desc = d;
        req_pending.push_back(it);
    endfunction

    function automatic void field_check(string fname, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            fails++;
        end
    endfunction

    // Drive the request channel; hold a word until it is taken.
    always @(negedge clk)
    begin
        ring_req_t nxt;
        if (!rst_n)
            req_if.valid <= 1'b0;
        else if (!req_if.valid || req_taken)
        begin
            if (req_pending.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                nxt = req_pending.pop_front();
                req_if.valid    <= 1'b1;
                req_if.opcode   <= nxt.op;
                req_if.in_addr  <= nxt.desc.addr;
                req_if.in_size  <= nxt.desc.size;
                req_if.in_flags <= nxt.desc.flags;
                req_if.in_kind  <= nxt.desc.kind;
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // Response backpressure, with one long hold while requests are still queued.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold       <= rx_hold - 1;
            rsp_if.ready  <= 1'b0;
        end
        else if (!rx_hold_done && words_in > 150 && req_pending.size() > 20)
        begin
            rx_hold       <= 300;
            rx_hold_done  <= 1'b1;
            rsp_if.ready  <= 1'b0;
        end
        else
            rsp_if.ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        desc_t d;
        req_taken <= req_if.valid && req_if.ready;
        if (rst_n)
        begin
            if (cfg_we)
                ring_resize_shadow(cfg_data);
            if (req_if.valid && req_if.ready)
            begin
                d.addr  = req_if.in_addr;
                d.size  = req_if.in_size;
                d.flags = req_if.in_flags;
                d.kind  = req_if.in_kind;
                due_results.push_back(ring_apply(op_t'(req_if.opcode), d));
                words_in++;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (due_results.size() == 0)
            begin
                $error("response word with nothing outstanding");
                fails++;
            end
            else
            begin
                w = due_results.pop_front();
                field_check("status", w.status, rsp_if.status);
                field_check("out_addr", w.desc.addr, rsp_if.out_addr);
                field_check("out_size", w.desc.size, rsp_if.out_size);
                field_check("out_flags", w.desc.flags, rsp_if.out_flags);
                field_check("out_kind", w.desc.kind, rsp_if.out_kind);
            end
        end
    end

    task automatic wait_drained();
        @(posedge clk);
        while (req_pending.size() > 0 || req_if.valid || due_results.size() > 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic ring_resize(logic [CFG_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        n_resize++;
    endtask

    initial begin
        int          phase_no;
        int          rand_words;
        int          n_items;
        int          put_pct;
        int          get_cut;
        int          key_pct;
        int          pick;
        logic [6:0]  slots;
        desc_t       ones;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        req_if.valid    = 1'b0;
        req_if.opcode   = OP_PUT;
        req_if.in_addr  = '0;
        req_if.in_size  = '0;
        req_if.in_flags = '0;
        req_if.in_kind  = '0;
        rsp_if.ready    = 1'b0;
        ones            = '1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // default ring: empty reads, field extremes, flush
        offer(OP_GET, '0);
        offer(OP_PEEK, '0);
        offer(OP_PUT, '0);
        offer(OP_PUT, ones);
        offer(OP_PUT, rand_desc(100));
        offer(OP_PEEK, '0);
        offer(OP_GET, '0);
        offer(OP_GET, '0);
        offer(OP_GET, '0);
        offer(OP_GET, '0);
        offer(OP_PUT, rand_desc(50));
        offer(OP_FLUSH, '0);
        offer(OP_PEEK, '0);

        // two slots: every put on a full ring empties it first
        ring_resize(7'd2);
        offer(OP_PUT, rand_desc(0));
        offer(OP_PUT, rand_desc(0));
        offer(OP_PEEK, '0);
        offer(OP_PUT, rand_desc(100));
        offer(OP_GET, '0);

        // three slots: drop walk stops on a keyframe
        ring_resize(7'd3);
        offer(OP_PUT, rand_desc(0));
        offer(OP_PUT, rand_desc(100));
        offer(OP_PUT, rand_desc(0));
        offer(OP_GET, '0);
        offer(OP_GET, '0);
        offer(OP_GET, '0);

        phase_no   = 0;
        rand_words = 0;
        while (rand_words < RAND_WORDS)
        begin
            case (phase_no)
                0: slots = 7'd0;
                1: slots = 7'd1;
                2: slots = 7'd127;
                3: slots = 7'd65;
                default:
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 6)
                        slots = 7'($urandom_range(0, 127));
                    else if (pick < 18)
                        slots = 7'd64;
                    else
                        slots = 7'($urandom_range(2, 9));
                end
            endcase
            ring_resize(slots);
            // one long stretch with no idling on either side
            idle_pct = (phase_no == 5) ? 0 : 33;

            if (slots >= 7'd64)
            begin
                n_items = $urandom_range(100, 200);
                put_pct = 70;
            end
            else
            begin
                n_items = $urandom_range(30, 90);
                pick    = $urandom_range(0, 2);
                put_pct = (pick == 0) ? 70 : (pick == 1) ? 45 : 30;
            end
            get_cut = put_pct + (96 - put_pct) * 2 / 3;
            key_pct = $urandom_range(5, 60);

            for (int i = 0; i < n_items; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < put_pct)
                    offer(OP_PUT, rand_desc(key_pct));
                else if (pick < get_cut)
                    offer(OP_GET, rand_desc(key_pct));
                else if (pick < 96)
                    offer(OP_PEEK, rand_desc(key_pct));
                else
                    offer(OP_FLUSH, rand_desc(key_pct));
            end
            rand_words += n_items;
            phase_no++;
        end

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Ran %0d requests over %0d ring sizes: %0d puts (%0d on a full ring,",
                 words_in, n_resize + 1, n_put, n_full_put);
        $display("  %0d drop walks ended on a keyframe), %0d gets, %0d peeks,",
                 n_key_stop, n_get, n_peek);
        $display("  %0d flushes, %0d empty reads", n_flush, n_empty);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: keyframe_drop_descriptor_ring_unit.f
hw/rtl/kdr_pkg.sv
hw/rtl/kdr_req_if.sv
hw/rtl/kdr_rsp_if.sv
hw/rtl/kdr_ram.sv
hw/rtl/kdr_ctrl.sv
hw/rtl/keyframe_drop_descriptor_ring_unit.sv
hw/rtl/kdr_checker.sv
tb/tb_keyframe_drop_descriptor_ring_unit.sv
